FILE: rtl/radius_leader_clustering_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radius leader clustering block.
// Define NO_ASSERTIONS to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef RADIUS_LEADER_CLUSTERING_ASSERT_SVH
`define RADIUS_LEADER_CLUSTERING_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, held off while reset is asserted.
`define RLC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define RLC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RLC_ASSERT(label, clk, rst_n, prop, msg)
`define RLC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: rtl/rlc_pkg.sv
// ---------------------------------------------------------------------------
// rlc_pkg
// Types, codes and defaults shared by the leader clustering modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlc_pkg;

    // Default sizing.
    localparam int MAX_GROUPS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths.
    localparam int RADIUS_W  = 34;
    localparam int MEMBER_W  = 6;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_IDX_W = 8;

    // Reset values of the configuration registers.
    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 34'd65536;
    localparam logic [MEMBER_W-1:0] MAXMEM_RESET  = 6'd15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQUARED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MEMBERS    = 8'd1;

    // Function codes of an input item.
    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_JOINED  = 3'd0;
    localparam logic [2:0] ST_FOUNDED = 3'd1;
    localparam logic [2:0] ST_DEAD    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // Input item.
    typedef struct packed {
        logic               func;
        logic               team;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               alive;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_IDX_W-1:0] group_index;
        logic [MEMBER_W-1:0]  member_count;
    } t_out;

    // Search token that walks the row of group cells.
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [OUT_IDX_W-1:0] idx;
        logic [MEMBER_W-1:0]  cnt;
    } t_probe;

    // Control states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

FILE: rtl/rlc_cell.sv
// ---------------------------------------------------------------------------
// rlc_cell
// One group slot: holds team, centre and member count, and tests the search
// token that passes through it against that group.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlc_cell #(
    parameter int MAX_GROUPS = rlc_pkg::MAX_GROUPS_DEF,
    parameter int COORD_BITS = rlc_pkg::COORD_BITS_DEF,
    parameter int IDX        = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rlc_pkg::t_probe                        i_probe,
    output rlc_pkg::t_probe                        o_probe,
    input  logic [$clog2(MAX_GROUPS+1)-1:0]        i_count,
    input  logic                                   i_team,
    input  logic [COORD_BITS-1:0]                  i_x,
    input  logic [COORD_BITS-1:0]                  i_y,
    input  logic [rlc_pkg::RADIUS_W-1:0]           i_radius,
    input  logic [rlc_pkg::MEMBER_W-1:0]           i_max_mem,
    input  logic                                   i_wr_en,
    input  logic [$clog2(MAX_GROUPS)-1:0]          i_wr_idx
);
    import rlc_pkg::*;

    localparam int CNTW = $clog2(MAX_GROUPS + 1);
    localparam int IW   = $clog2(MAX_GROUPS);
    localparam int SW   = 2 * COORD_BITS + 3;
    localparam int DW   = (SW > RADIUS_W) ? SW : RADIUS_W;

    logic                  r_team;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [MEMBER_W-1:0]   r_mem;
    t_probe                r_probe;

    logic [COORD_BITS:0]     w_dx;
    logic [COORD_BITS:0]     w_dy;
    logic [COORD_BITS:0]     w_mx;
    logic [COORD_BITS:0]     w_my;
    logic [2*COORD_BITS+1:0] w_sx;
    logic [2*COORD_BITS+1:0] w_sy;
    logic [SW-1:0]           w_sum;
    logic                    w_active;
    logic                    w_near;
    logic                    w_hit;
    logic                    w_wr;

    // Exact differences, one bit wider than a coordinate.
    assign w_dx = {i_x[COORD_BITS-1], i_x} - {r_cx[COORD_BITS-1], r_cx};
    assign w_dy = {i_y[COORD_BITS-1], i_y} - {r_cy[COORD_BITS-1], r_cy};

    // Magnitudes and their squares; the two multipliers work side by side.
    assign w_mx  = w_dx[COORD_BITS] ? (~w_dx + 1'b1) : w_dx;
    assign w_my  = w_dy[COORD_BITS] ? (~w_dy + 1'b1) : w_dy;
    assign w_sx  = w_mx * w_mx;
    assign w_sy  = w_my * w_my;
    assign w_sum = SW'(w_sx) + SW'(w_sy);

    // Join test for this group.
    assign w_active = CNTW'(IDX) < i_count;
    assign w_near   = DW'(w_sum) < DW'(i_radius);
    assign w_hit    = i_probe.valid && !i_probe.hit && w_active &&
                      (r_mem < i_max_mem) && (r_team == i_team) && w_near;
    assign w_wr     = i_wr_en && (i_wr_idx == IW'(IDX));

    // Group contents: founded by a write, grown by a join.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_team <= i_team;
            r_cx   <= i_x;
            r_cy   <= i_y;
            r_mem  <= MEMBER_W'(1);
        end else if (w_hit) begin
            r_mem  <= MEMBER_W'(r_mem + 1'b1);
        end
    end

    // Hand the token on to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe.valid <= i_probe.valid;
            r_probe.hit   <= i_probe.hit || w_hit;
            r_probe.idx   <= w_hit ? OUT_IDX_W'(IDX) : i_probe.idx;
            r_probe.cnt   <= w_hit ? MEMBER_W'(r_mem + 1'b1) : i_probe.cnt;
        end
    end

    assign o_probe = r_probe;

endmodule

FILE: rtl/radius_leader_clustering.sv
// ---------------------------------------------------------------------------
// radius_leader_clustering
// A live place launches a search token that walks the row of group cells,
// one group cell per cycle; clear and dead items skip the search.
// Throughput: one item at a time; the next item is taken once the result has
// entered the output register, which waits while the output is stalled.
// Synchronous active-low reset empties the group table and restores the
// register defaults; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radius_leader_clustering_assert.svh"

module radius_leader_clustering #(
    parameter int MAX_GROUPS = rlc_pkg::MAX_GROUPS_DEF,
    parameter int COORD_BITS = rlc_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rlc_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rlc_pkg::t_out                   o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rlc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rlc_pkg::RADIUS_W-1:0]    i_cfg_data
);
    import rlc_pkg::*;

    localparam int CNTW = $clog2(MAX_GROUPS + 1);
    localparam int IW   = $clog2(MAX_GROUPS);

    t_state                r_state;
    t_state                n_state;
    logic [CNTW-1:0]       r_count;
    logic                  r_team;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic                  r_launch;
    logic [RADIUS_W-1:0]   r_radius;
    logic [MEMBER_W-1:0]   r_max_mem;
    t_out                  r_res;
    t_out                  r_out;
    logic                  r_out_valid;

    logic                  w_in_acc;
    logic                  w_load_out;
    logic                  w_scan_end;
    logic                  w_room;
    logic                  w_wr_en;
    logic [COORD_BITS-1:0] w_x;
    logic [COORD_BITS-1:0] w_y;
    t_probe                w_chain [MAX_GROUPS+1];

    // Coordinates at the configured width, sign-extended or truncated.
    generate
        if (COORD_BITS <= 16) begin : g_narrow
            assign w_x = i_in.pos_x[COORD_BITS-1:0];
            assign w_y = i_in.pos_y[COORD_BITS-1:0];
        end else begin : g_wide
            assign w_x = COORD_BITS'(i_in.pos_x);
            assign w_y = COORD_BITS'(i_in.pos_y);
        end
    endgenerate

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_RESET;
            r_max_mem <= MAXMEM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RADIUS_SQUARED: r_radius  <= i_cfg_data;
                REG_MAX_MEMBERS:    r_max_mem <= i_cfg_data[MEMBER_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller outputs.
    assign w_scan_end = w_chain[MAX_GROUPS].valid;
    assign w_room     = r_count < CNTW'(MAX_GROUPS);

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        w_wr_en    = (r_state == S_SCAN) && w_scan_end &&
                     !w_chain[MAX_GROUPS].hit && w_room;
    end

    assign w_in_acc = i_in_valid && o_in_ready;

    // Controller next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.func == FUNC_PLACE && i_in.alive) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Group count and launch of the search token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_launch <= 1'b0;
        end else begin
            r_launch <= w_in_acc && (i_in.func == FUNC_PLACE) && i_in.alive;
            if (w_in_acc && i_in.func == FUNC_CLEAR) begin
                r_count <= '0;
            end else if (w_wr_en) begin
                r_count <= CNTW'(r_count + 1'b1);
            end
        end
    end

    // Point held for the whole search and for founding.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_team <= i_in.team;
            r_x    <= w_x;
            r_y    <= w_y;
        end
    end

    // Result of the current item.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res.group_index  <= '0;
            r_res.member_count <= '0;
            r_res.status       <= (i_in.func == FUNC_CLEAR) ? ST_CLEARED : ST_DEAD;
        end else if (r_state == S_SCAN && w_scan_end) begin
            if (w_chain[MAX_GROUPS].hit) begin
                r_res.status       <= ST_JOINED;
                r_res.group_index  <= w_chain[MAX_GROUPS].idx;
                r_res.member_count <= w_chain[MAX_GROUPS].cnt;
            end else if (w_room) begin
                r_res.status       <= ST_FOUNDED;
                r_res.group_index  <= OUT_IDX_W'(r_count);
                r_res.member_count <= MEMBER_W'(1);
            end else begin
                r_res.status       <= ST_FULL;
                r_res.group_index  <= '0;
                r_res.member_count <= '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Row of group cells.
    assign w_chain[0] = '{valid: r_launch, hit: 1'b0, idx: '0, cnt: '0};

    generate
        for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
            rlc_cell #(
                .MAX_GROUPS (MAX_GROUPS),
                .COORD_BITS (COORD_BITS),
                .IDX        (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_probe   (w_chain[g]),
                .o_probe   (w_chain[g+1]),
                .i_count   (r_count),
                .i_team    (r_team),
                .i_x       (r_x),
                .i_y       (r_y),
                .i_radius  (r_radius),
                .i_max_mem (r_max_mem),
                .i_wr_en   (w_wr_en),
                .i_wr_idx  (r_count[IW-1:0])
            );
        end
    endgenerate

    // Checks.
    `RLC_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNTW'(MAX_GROUPS), "group count overflow")
    `RLC_ASSERT(a_token_in_scan, i_clk, i_rst_n, w_scan_end |-> r_state == S_SCAN, "token exit outside search")
    `RLC_ASSERT(a_found_grows, i_clk, i_rst_n, w_wr_en |=> r_count == CNTW'($past(r_count) + 1'b1), "founding did not grow table")
    `RLC_ASSERT(a_clear_empties, i_clk, i_rst_n, (w_in_acc && i_in.func == FUNC_CLEAR) |=> r_count == '0, "clear did not empty table")
    `RLC_ASSERT(a_join_count, i_clk, i_rst_n, (w_load_out && r_res.status == ST_JOINED) |-> (r_res.member_count != '0 && r_res.member_count <= r_max_mem), "joined count out of range")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the radius leader clustering block. Points and clear commands
// go in over a valid/ready channel, and the block's group table is tracked
// by a local model that predicts status, group index and member count for
// every item. Results are checked in order as they leave the block. Both
// channels idle and stall at random, and register writes happen only while
// the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
    import rlc_pkg::*;

    localparam int LATENCY     = MAX_GROUPS_DEF + 3;
    localparam int CYCLE_LIMIT = 400000;

    // Radius settings of interest: all ones, 2^33, and the squared
    // distance between opposite corners of the coordinate range.
    localparam logic [RADIUS_W-1:0] RADIUS_MAX   = '1;
    localparam logic [RADIUS_W-1:0] RADIUS_HALF  = 34'h2_0000_0000;
    localparam logic [RADIUS_W-1:0] CORNER_DIST2 = 34'd8589672450;
    localparam logic [RADIUS_W-1:0] RADIUS_1M    = 34'h0_0010_0000;

    // Indexes that select no register.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COORD_MIN = 16'sh8000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_item = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RADIUS_W-1:0]  cfg_data = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_cfg_ready;
    t_out                 out_item;

    // Local copy of the registers and the group table.
    logic [RADIUS_W-1:0]  cfg_radius2 = RADIUS_RESET;
    logic [MEMBER_W-1:0]  cfg_max_members = MAXMEM_RESET;
    int                   tbl_count = 0;
    logic                 tbl_team    [MAX_GROUPS_DEF];
    logic signed [15:0]   tbl_cx      [MAX_GROUPS_DEF];
    logic signed [15:0]   tbl_cy      [MAX_GROUPS_DEF];
    logic [MEMBER_W-1:0]  tbl_members [MAX_GROUPS_DEF];

    t_out        expected_q[$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    int unsigned out_hold = 0;

    radius_leader_clustering uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap before an item, on either side; none during calm stretches.
    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // Random coordinate with the range ends drawn now and then.
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            default: return 16'($urandom);
        endcase
    endfunction

    // Coordinate within a given spread of a centre, wrapping at the ends.
    function automatic logic signed [15:0] jitter(input logic signed [15:0] c,
                                                  input int unsigned spread);
        int off;
        off = int'($urandom_range(0, 2 * spread)) - int'(spread);
        return c + 16'(off);
    endfunction

    function automatic t_in point(input logic team, input logic signed [15:0] x,
                                  input logic signed [15:0] y, input logic alive);
        t_in it;
        it.func  = FUNC_PLACE;
        it.team  = team;
        it.pos_x = x;
        it.pos_y = y;
        it.alive = alive;
        return it;
    endfunction

    // Clear command; the other fields carry random values.
    function automatic t_in clear_cmd();
        t_in it;
        it = point(1'($urandom), rand_coord(), rand_coord(), 1'($urandom));
        it.func = FUNC_CLEAR;
        return it;
    endfunction

    // Places one point in the local group table and returns the result the
    // block should give for it.
    function automatic t_out place_in_table(input t_in it);
        t_out            res;
        longint          dx;
        longint          dy;
        longint unsigned d2;
        int              g;
        res = '0;
        if (it.func == FUNC_CLEAR) begin
            tbl_count = 0;
            res.status = ST_CLEARED;
            return res;
        end
        if (!it.alive) begin
            res.status = ST_DEAD;
            return res;
        end
        // First group in index order with room, same team and close enough.
        for (g = 0; g < tbl_count; g++) begin
            if (tbl_members[g] < cfg_max_members && tbl_team[g] == it.team) begin
                dx = longint'($signed(it.pos_x)) - longint'($signed(tbl_cx[g]));
                dy = longint'($signed(it.pos_y)) - longint'($signed(tbl_cy[g]));
                d2 = dx * dx + dy * dy;
                if (d2 < cfg_radius2) begin
                    tbl_members[g] = tbl_members[g] + 1'b1;
                    res.status       = ST_JOINED;
                    res.group_index  = OUT_IDX_W'(g);
                    res.member_count = tbl_members[g];
                    return res;
                end
            end
        end
        if (tbl_count >= MAX_GROUPS_DEF) begin
            res.status = ST_FULL;
            return res;
        end
        // No group fits: found a new one centred on the point.
        g = tbl_count;
        tbl_team[g]    = it.team;
        tbl_cx[g]      = it.pos_x;
        tbl_cy[g]      = it.pos_y;
        tbl_members[g] = MEMBER_W'(1);
        tbl_count++;
        res.status       = ST_FOUNDED;
        res.group_index  = OUT_IDX_W'(g);
        res.member_count = MEMBER_W'(1);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        $display("ERROR cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected result, status", 8'(got.status), 8'd0);
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 8'(got.status), 8'(want.status));
        if (got.group_index !== want.group_index)
            report_mismatch("group_index", 8'(got.group_index), 8'(want.group_index));
        if (got.member_count !== want.member_count)
            report_mismatch("member_count", 8'(got.member_count), 8'(want.member_count));
    endtask

    // Sends one item and records its expected result once it is accepted.
    task automatic send_item(input t_in it);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
        expected_q.push_back(place_in_table(it));
    endtask

    // Writes one register; the caller lowers cfg_valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [RADIUS_W-1:0] val);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == REG_RADIUS_SQUARED)
            cfg_radius2 = val;
        else if (idx == REG_MAX_MEMBERS)
            cfg_max_members = val[MEMBER_W-1:0];
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [RADIUS_W-1:0] radius2,
                              input logic [MEMBER_W-1:0] max_mem);
        wait_drained();
        write_reg(REG_RADIUS_SQUARED, radius2);
        write_reg(REG_MAX_MEMBERS, RADIUS_W'(max_mem));
        cfg_valid <= 1'b0;
    endtask

    // Joining just inside the radius, founding exactly on it.
    task automatic test_join_boundary();
        set_config(RADIUS_RESET, MAXMEM_RESET);
        send_item(point(1'b0, 16'sd0, 16'sd0, 1'b1));
        send_item(point(1'b0, 16'sd255, 16'sd0, 1'b1));
        send_item(point(1'b0, 16'sd0, 16'sd256, 1'b1));
        send_item(point(1'b0, -16'sd181, -16'sd181, 1'b1));
    endtask

    // Other team founds its own group; dead points and clears.
    task automatic test_team_and_dead();
        send_item(point(1'b1, 16'sd0, 16'sd0, 1'b1));
        send_item(point(1'b1, 16'sd0, 16'sd0, 1'b0));
        send_item(clear_cmd());
    endtask

    // Opposite corners join under the widest radius, but not at exactly
    // their own squared distance.
    task automatic test_coord_extremes();
        set_config(RADIUS_MAX, 6'd63);
        send_item(point(1'b0, COORD_MAX, COORD_MAX, 1'b1));
        send_item(point(1'b0, COORD_MIN, COORD_MIN, 1'b1));
        set_config(CORNER_DIST2, 6'd63);
        send_item(clear_cmd());
        send_item(point(1'b1, COORD_MAX, COORD_MAX, 1'b1));
        send_item(point(1'b1, COORD_MIN, COORD_MIN, 1'b1));
    endtask

    // With a zero radius even a repeated point founds again.
    task automatic test_radius_zero();
        set_config('0, MAXMEM_RESET);
        send_item(clear_cmd());
        send_item(point(1'b0, 16'sd100, -16'sd100, 1'b1));
        send_item(point(1'b0, 16'sd100, -16'sd100, 1'b1));
    endtask

    // With no room allowed, groups never take joiners.
    task automatic test_no_joiners();
        set_config(RADIUS_MAX, '0);
        send_item(clear_cmd());
        send_item(point(1'b1, -16'sd5, 16'sd7, 1'b1));
        send_item(point(1'b1, -16'sd5, 16'sd7, 1'b1));
    endtask

    // Writes to indexes past the register list must change nothing.
    task automatic test_unknown_register();
        wait_drained();
        write_reg(REG_RADIUS_SQUARED, RADIUS_1M);
        write_reg(REG_MAX_MEMBERS, RADIUS_W'(MAXMEM_RESET));
        write_reg(REG_UNUSED_LO, '0);
        write_reg(REG_UNUSED_HI, '0);
        cfg_valid <= 1'b0;
        send_item(clear_cmd());
        send_item(point(1'b0, 16'sd3, 16'sd3, 1'b1));
        send_item(point(1'b0, 16'sd3, 16'sd3, 1'b1));
    endtask

    // One group fills up to 63 members, the next point founds a second group.
    task automatic test_member_limit();
        int k;
        calm = 1'b1;
        set_config(RADIUS_MAX, 6'd63);
        send_item(clear_cmd());
        for (k = 0; k < 64; k++)
            send_item(point(1'b0, rand_coord(), rand_coord(), 1'b1));
        calm = 1'b0;
    endtask

    // Fill all groups, then see full status, joins while full, and full again
    // once no group has room.
    task automatic test_full_table();
        int k;
        set_config('0, 6'($urandom_range(1, 63)));
        send_item(clear_cmd());
        while (tbl_count < MAX_GROUPS_DEF)
            send_item(point(1'($urandom), rand_coord(), rand_coord(),
                            $urandom_range(0, 7) != 0));
        for (k = 0; k < 5; k++)
            send_item(point(1'($urandom), rand_coord(), rand_coord(), 1'b1));
        set_config(RADIUS_MAX, 6'd63);
        for (k = 0; k < 5; k++)
            send_item(point(1'($urandom), rand_coord(), rand_coord(), 1'b1));
        set_config(RADIUS_MAX, 6'd1);
        for (k = 0; k < 5; k++)
            send_item(point(1'($urandom), rand_coord(), rand_coord(), 1'b1));
    endtask

    // Mostly points near existing centres, with clears, dead points and
    // scattered points mixed in.
    task automatic test_random_clusters(input logic [RADIUS_W-1:0] radius2,
                                        input logic [MEMBER_W-1:0] max_mem,
                                        input int n_items);
        t_in it;
        int  k;
        int  g;
        set_config(radius2, max_mem);
        for (k = 0; k < n_items; k++) begin
            if ((k % 20) == 0)
                calm = ($urandom_range(0, 3) == 0);
            it = point(1'($urandom), rand_coord(), rand_coord(), 1'b1);
            if (tbl_count > 0 && $urandom_range(0, 2) != 0) begin
                g = $urandom_range(0, tbl_count - 1);
                it.pos_x = jitter(tbl_cx[g], 600);
                it.pos_y = jitter(tbl_cy[g], 600);
                if ($urandom_range(0, 3) != 0)
                    it.team = tbl_team[g];
            end
            case ($urandom_range(0, 19))
                0:       it = clear_cmd();
                1, 2:    it.alive = 1'b0;
                default: ;
            endcase
            send_item(it);
        end
        calm = 1'b0;
    endtask

    // Result side: check each accepted result, then stall for a drawn number
    // of cycles while a result is waiting.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                check_result(out_item);
                out_hold = draw_wait();
            end else if (o_out_valid && out_hold > 0) begin
                out_hold--;
            end
            out_ready <= (out_hold == 0);
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("radius_leader_clustering: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_join_boundary();
        test_team_and_dead();
        test_coord_extremes();
        test_radius_zero();
        test_no_joiners();
        test_unknown_register();
        test_member_limit();
        test_full_table();
        test_random_clusters(RADIUS_RESET, MAXMEM_RESET, 60);
        test_random_clusters(RADIUS_1M, 6'd3, 60);
        test_random_clusters(RADIUS_W'($urandom_range(0, 1 << 22)),
                             6'($urandom_range(0, 63)), 60);
        test_random_clusters(RADIUS_HALF, 6'($urandom_range(1, 63)), 60);

        // Let any stray result show up before the verdict.
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("radius_leader_clustering: match");
        else
            $display("radius_leader_clustering: mismatch");
        $finish;
    end

endmodule
